### hw/rtl/dwt53_forward_lifting_line_assert.svh
// assertion macros for the 5/3 forward lifting line
// no dependencies; included by the files that carry assertions
`ifndef DWT53_FORWARD_LIFTING_LINE_ASSERT_SVH
`define DWT53_FORWARD_LIFTING_LINE_ASSERT_SVH
`ifndef SYNTHESIS
// expression holds at every clock edge outside reset
`define DWT53_ASSERT_HOLDS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("dwt53: invariant violated");
// consequent holds in the cycle after the antecedent
`define DWT53_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dwt53: next-cycle check failed");
`else
`define DWT53_ASSERT_HOLDS(label, clk, rstn, expr)
`define DWT53_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/dwt53_pkg.sv
// shared types and constants of the 5/3 forward lifting line
// no dependencies; imported by dwt53_forward_lifting_line and its bench
`timescale 1ns / 1ps

package dwt53_pkg;

    // defaults for the top-level parameters
    localparam int DWT_MAX_LINE_LENGTH = 4096;
    localparam int DWT_SAMPLE_BITS     = 16;

    // fixed field widths
    localparam int COEFF_BITS     = 18;
    localparam int LEN_BITS       = 13;
    localparam int CFG_INDEX_BITS = 1;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_LENGTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_PARITY = 1'b1;

    // result queue
    localparam int FIFO_DEPTH     = 8;
    localparam int FIFO_PTR_BITS  = 3;
    localparam int FIFO_CNT_BITS  = FIFO_PTR_BITS + 1;
    localparam int MAX_PUSH       = 3;
    localparam int PUSH_BITS      = 2;

    typedef struct packed {
        logic signed [COEFF_BITS-1:0] coeff;
        logic                         is_high;
        logic                         last;
    } result_t;

endpackage

### hw/rtl/dwt53_forward_lifting_line.sv
// reversible 5/3 forward lifting of one image line, streaming
// depends on dwt53_pkg and dwt53_forward_lifting_line_assert.svh
`timescale 1ns / 1ps
`include "dwt53_forward_lifting_line_assert.svh"

// channel  | handshake          | payload
// ---------+--------------------+--------------------------------
// config   | cfg_we             | cfg_index, cfg_wdata
// input    | s_valid / s_ready  | s_sample
// result   | m_valid / m_ready  | m_coeff, m_is_high, m_last
//
// one sample per cycle sustained while m_ready stays high; a sample waits in the
// input register until the queue has room, and its coefficients enter an 8-entry
// result queue at the end of that cycle. up to three coefficients per sample
// enter the queue at once; it drains one per cycle while m_ready is high, and
// s_ready drops while a sample waits and fewer than three queue slots are free.
// aresetn is synchronous, active low; registers return to length 1, parity 0.
module dwt53_forward_lifting_line
    import dwt53_pkg::*;
#(
    parameter int MAX_LINE_LENGTH = DWT_MAX_LINE_LENGTH,
    parameter int SAMPLE_BITS     = DWT_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [LEN_BITS-1:0]           cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COEFF_BITS-1:0]  m_coeff,
    output logic                          m_is_high,
    output logic                          m_last
);

    localparam int CNT_BITS  = $clog2(MAX_LINE_LENGTH);
    localparam int LSAT_BITS = $clog2(MAX_LINE_LENGTH + 1);
    localparam int CMP_BITS  = ((LSAT_BITS > LEN_BITS) ? LSAT_BITS : LEN_BITS) + 1;
    localparam int HIGH_BITS = SAMPLE_BITS + 2;
    localparam int EW        = ((SAMPLE_BITS + 4) > COEFF_BITS) ? (SAMPLE_BITS + 4)
                                                                : COEFF_BITS;
    localparam logic signed [EW-1:0] TWO = EW'(2);

    // configuration and control registers
    logic [LEN_BITS-1:0]      line_len_reg;
    logic                     start_par_reg;
    logic                     in_vld_reg;
    logic [CNT_BITS-1:0]      sample_cnt_reg;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [FIFO_CNT_BITS-1:0] fifo_cnt_reg;
    logic [FIFO_CNT_BITS-1:0] fifo_cnt_next;

    // payload registers
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic signed [SAMPLE_BITS-1:0] win0_reg;
    logic signed [SAMPLE_BITS-1:0] win1_reg;
    logic signed [SAMPLE_BITS-1:0] pend_low_reg;
    logic signed [HIGH_BITS-1:0]   prev_high_reg;
    result_t                       fifo_reg [FIFO_DEPTH];

    // handshake
    logic proc;
    logic s_xfer;
    logic pop;

    assign proc    = in_vld_reg && (fifo_cnt_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - MAX_PUSH));
    assign s_ready = !in_vld_reg || proc;
    assign s_xfer  = s_valid && s_ready;
    assign m_valid = (fifo_cnt_reg != '0);
    assign pop     = m_valid && m_ready;

    // effective line length and position flags
    logic [CMP_BITS-1:0] len_wide;
    logic [CMP_BITS-1:0] len_sat;
    logic [CMP_BITS-1:0] cnt_wide;
    logic                is_last;
    logic                cur_high;
    logic                k_ge1;
    logic                k_ge2;
    logic                k_ge3;

    always_comb begin
        len_wide = CMP_BITS'(line_len_reg);
        if (len_wide == '0) begin
            len_sat = CMP_BITS'(1);
        end else if (len_wide > CMP_BITS'(MAX_LINE_LENGTH)) begin
            len_sat = CMP_BITS'(MAX_LINE_LENGTH);
        end else begin
            len_sat = len_wide;
        end
    end

    assign cnt_wide = CMP_BITS'(sample_cnt_reg);
    assign is_last  = (cnt_wide + CMP_BITS'(1)) >= len_sat;
    assign cur_high = start_par_reg ^ sample_cnt_reg[0];
    assign k_ge1    = (cnt_wide != '0);
    assign k_ge2    = (cnt_wide >= CMP_BITS'(2));
    assign k_ge3    = (cnt_wide >= CMP_BITS'(3));

    // lifting arithmetic
    logic signed [EW-1:0] xe;
    logic signed [EW-1:0] w0e;
    logic signed [EW-1:0] w1e;
    logic signed [EW-1:0] ple;
    logic signed [EW-1:0] phe;
    logic signed [EW-1:0] left_e;
    logic signed [EW-1:0] h_even;
    logic signed [EW-1:0] h_odd;
    logic signed [EW-1:0] h_val;
    logic signed [EW-1:0] hl_val;
    logic signed [EW-1:0] low_val;
    logic signed [EW-1:0] tail_val;
    logic signed [EW-1:0] single_val;
    logic                 hl_prev;

    assign xe         = EW'(in_sample_reg);
    assign w0e        = EW'(win0_reg);
    assign w1e        = EW'(win1_reg);
    assign ple        = EW'(pend_low_reg);
    assign phe        = EW'(prev_high_reg);
    assign left_e     = k_ge2 ? w1e : xe;
    assign h_even     = w0e - ((left_e + xe) >>> 1);
    assign h_odd      = xe - w0e;
    assign h_val      = cur_high ? h_odd : h_even;
    assign hl_prev    = cur_high ? k_ge2 : k_ge3;
    assign hl_val     = hl_prev ? phe : h_val;
    assign low_val    = ple + ((hl_val + h_val + TWO) >>> 2);
    assign tail_val   = xe + ((h_val + h_val + TWO) >>> 2);
    assign single_val = cur_high ? (xe + xe) : xe;

    // results of the current sample, in output order
    result_t              res [MAX_PUSH];
    logic [PUSH_BITS-1:0] push_n;
    result_t              low_res;
    result_t              high_res;
    result_t              tail_res;

    assign low_res  = '{coeff: low_val[COEFF_BITS-1:0], is_high: 1'b0, last: 1'b0};
    assign high_res = '{coeff: h_val[COEFF_BITS-1:0], is_high: 1'b1, last: is_last && cur_high};
    assign tail_res = '{coeff: tail_val[COEFF_BITS-1:0], is_high: 1'b0, last: 1'b1};

    always_comb begin
        res[0] = low_res;
        res[1] = high_res;
        res[2] = tail_res;
        push_n = '0;
        if (!k_ge1) begin
            // first position: emits only for a one-sample line
            res[0] = '{coeff: single_val[COEFF_BITS-1:0], is_high: cur_high, last: 1'b1};
            push_n = is_last ? PUSH_BITS'(1) : PUSH_BITS'(0);
        end else if (!cur_high) begin
            // previous high position now has both neighbors
            if (k_ge2) begin
                push_n = is_last ? PUSH_BITS'(3) : PUSH_BITS'(2);
            end else begin
                res[0] = high_res;
                res[1] = tail_res;
                push_n = is_last ? PUSH_BITS'(2) : PUSH_BITS'(1);
            end
        end else if (is_last) begin
            // line ends on a high position
            push_n = PUSH_BITS'(2);
        end
        if (!proc) begin
            push_n = '0;
        end
    end

    // queue write addresses
    logic [FIFO_PTR_BITS-1:0] wr_idx [MAX_PUSH];

    always_comb begin
        for (int i = 0; i < MAX_PUSH; i++) begin
            wr_idx[i] = wr_ptr_reg + FIFO_PTR_BITS'(i);
        end
    end

    assign fifo_cnt_next = fifo_cnt_reg + FIFO_CNT_BITS'(push_n) - FIFO_CNT_BITS'(pop);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_len_reg   <= LEN_BITS'(1);
            start_par_reg  <= 1'b0;
            in_vld_reg     <= 1'b0;
            sample_cnt_reg <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_cnt_reg   <= '0;
        end else begin
            if (s_xfer) begin
                in_vld_reg <= 1'b1;
            end else if (proc) begin
                in_vld_reg <= 1'b0;
            end
            if (cfg_we) begin
                sample_cnt_reg <= '0;
                case (cfg_index)
                    REG_LINE_LENGTH: begin
                        line_len_reg <= cfg_wdata;
                    end
                    REG_START_PARITY: begin
                        start_par_reg <= cfg_wdata[0];
                    end
                    default: begin
                    end
                endcase
            end else if (proc) begin
                sample_cnt_reg <= is_last ? '0 : (sample_cnt_reg + CNT_BITS'(1));
            end
            wr_ptr_reg   <= wr_ptr_reg + FIFO_PTR_BITS'(push_n);
            rd_ptr_reg   <= rd_ptr_reg + FIFO_PTR_BITS'(pop);
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    // sample window, lifting state and result queue
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_sample_reg <= s_sample;
        end
        if (proc) begin
            win1_reg <= win0_reg;
            win0_reg <= in_sample_reg;
            if (!cur_high) begin
                pend_low_reg <= in_sample_reg;
            end
            if (k_ge1 && (!cur_high || is_last)) begin
                prev_high_reg <= h_val[HIGH_BITS-1:0];
            end
        end
        for (int i = 0; i < MAX_PUSH; i++) begin
            if (PUSH_BITS'(i) < push_n) begin
                fifo_reg[wr_idx[i]] <= res[i];
            end
        end
    end

    // result channel
    assign m_coeff   = fifo_reg[rd_ptr_reg].coeff;
    assign m_is_high = fifo_reg[rd_ptr_reg].is_high;
    assign m_last    = fifo_reg[rd_ptr_reg].last;

    // checks
    `DWT53_ASSERT_HOLDS(a_fifo_bound, aclk, aresetn, fifo_cnt_reg <= FIFO_CNT_BITS'(FIFO_DEPTH))
    `DWT53_ASSERT_HOLDS(a_pos_in_line, aclk, aresetn, cnt_wide < len_sat)
    `DWT53_ASSERT_NEXT(a_line_restart, aclk, aresetn, proc && is_last, sample_cnt_reg == '0)
    `DWT53_ASSERT_NEXT(a_fifo_grows, aclk, aresetn, (push_n != '0) && !pop, fifo_cnt_reg > $past(fifo_cnt_reg))

endmodule

### bench/tb_dwt53_forward_lifting_line.sv
// self-checking bench for the streaming 5/3 forward lifting line
// depends on dwt53_pkg and dwt53_forward_lifting_line; predicts coefficients in-bench
`timescale 1ns / 1ps

module tb_dwt53_forward_lifting_line
    import dwt53_pkg::*;
();

    localparam int SMP_W          = DWT_SAMPLE_BITS;
    localparam int MAX_LEN        = DWT_MAX_LINE_LENGTH;
    localparam int PAD_BITS       = LEN_BITS - 1;
    localparam int RANDOM_ITEMS   = 200;
    localparam int FILL_SAMPLES   = 60;
    localparam int FILL_HOLD      = 120;
    localparam int SETTLE_CYCLES  = 6;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int N_ROWS         = 28;

    typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_SAMPLE_CHK} row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic [CFG_INDEX_BITS-1:0]   idx;
        logic [LEN_BITS-1:0]         val;
        logic signed [SMP_W-1:0]     smp;
        logic signed [COEFF_BITS-1:0] w_coeff;
        logic                        w_high;
        logic                        w_last;
    } stim_row_t;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_we;
    logic [CFG_INDEX_BITS-1:0]    cfg_index;
    logic [LEN_BITS-1:0]          cfg_wdata;
    logic                         s_valid;
    logic                         s_ready;
    logic signed [SMP_W-1:0]      s_sample;
    logic                         m_valid;
    logic                         m_ready;
    logic signed [COEFF_BITS-1:0] m_coeff;
    logic                         m_is_high;
    logic                         m_last;

    // expected coefficients, oldest first
    result_t coeff_expect_q[$];
    result_t head_want;
    int      fail_count = 0;
    int      cycle_count = 0;

    // predictor copy of registers and line state
    logic [LEN_BITS-1:0] line_len_cfg;
    logic                parity_cfg;
    int                  win[3];
    int                  last_high;
    int                  held_low;
    int                  pos_in_line;

    // sequencing flags shared with the receiver
    bit calm = 1'b0;
    bit fill_hold_req = 1'b0;
    bit fill_hold_done = 1'b0;

    stim_row_t directed_rows [0:N_ROWS-1];

    dwt53_forward_lifting_line dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_coeff   (m_coeff),
        .m_is_high (m_is_high),
        .m_last    (m_last)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // zero and oversize lengths behave as 1 and the maximum
    function automatic int clamp_len(input logic [LEN_BITS-1:0] len);
        int n;
        n = int'(len);
        if (n == 0)
            n = 1;
        if (n > MAX_LEN)
            n = MAX_LEN;
        return n;
    endfunction

    function automatic void push_coeff(input int c, input bit hi, input bit lst);
        result_t r;
        r.coeff   = c[COEFF_BITS-1:0];
        r.is_high = hi;
        r.last    = lst;
        coeff_expect_q.push_back(r);
    endfunction

    // one lifting step per accepted sample; >>> on int floors
    function automatic void lift_sample(input logic signed [SMP_W-1:0] smp);
        int  k;
        int  x;
        int  h;
        int  hl;
        int  left;
        bit  at_end;
        bit  hi_pos;
        k = pos_in_line;
        x = int'(smp);
        win[2] = win[1];
        win[1] = win[0];
        win[0] = x;
        at_end = (k + 1 >= clamp_len(line_len_cfg));
        hi_pos = ((parity_cfg + k) % 2) != 0;
        if (k == 0 && at_end) begin
            // one-sample line: pass through, doubled at a high position
            push_coeff(hi_pos ? 2 * x : x, hi_pos, 1'b1);
            pos_in_line = 0;
        end else begin
            if (k >= 1 && !hi_pos) begin
                // previous position is high-pass and now has both neighbors
                left = (k >= 2) ? win[2] : win[0];
                h = win[1] - ((left + win[0]) >>> 1);
                if (k >= 2) begin
                    hl = (k >= 3) ? last_high : h;
                    push_coeff(held_low + ((hl + h + 2) >>> 2), 1'b0, 1'b0);
                end
                last_high = h;
                push_coeff(h, 1'b1, 1'b0);
                if (at_end)
                    push_coeff(x + ((2 * h + 2) >>> 2), 1'b0, 1'b1);
            end else if (k >= 1 && at_end) begin
                // final high position uses its left neighbor as the mirrored right one
                h = x - win[1];
                hl = (k >= 2) ? last_high : h;
                push_coeff(held_low + ((hl + h + 2) >>> 2), 1'b0, 1'b0);
                last_high = h;
                push_coeff(h, 1'b1, 1'b1);
            end
            if (!hi_pos)
                held_low = x;
            pos_in_line = at_end ? 0 : k + 1;
        end
    endfunction

    // mixed sample values: full range, extremes, near zero
    function automatic logic signed [SMP_W-1:0] pick_sample();
        logic signed [SMP_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'sh8000;
            1: v = 16'sh7FFF;
            2, 3, 4: v = SMP_W'(int'($urandom_range(0, 16)) - 8);
            default: v = SMP_W'($urandom);
        endcase
        return v;
    endfunction

    // register write; any write restarts the line
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [LEN_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_LINE_LENGTH)
            line_len_cfg = val;
        else
            parity_cfg = val[0];
        pos_in_line = 0;
        @(posedge aclk);
    endtask

    // offer one sample, with an optional idle burst before it
    task automatic send_sample(input logic signed [SMP_W-1:0] v);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        lift_sample(v);
    endtask

    // stop offering, wait for every expected transfer, then let the pipe settle
    task automatic drain_line();
        s_valid <= 1'b0;
        while (coeff_expect_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one random configuration followed by whole lines and at most one broken line
    task automatic run_phase(output int sent);
        logic [LEN_BITS-1:0] len;
        logic                par;
        int                  eff;
        int                  n_lines;
        int                  n_part;
        sent = 0;
        case ($urandom_range(0, 9))
            0: len = '0;
            1: len = LEN_BITS'(1);
            2: len = LEN_BITS'(2);
            3: len = LEN_BITS'($urandom_range(MAX_LEN + 1, (1 << LEN_BITS) - 1));
            4, 5: len = LEN_BITS'($urandom_range(13, 64));
            default: len = LEN_BITS'($urandom_range(3, 12));
        endcase
        par = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_LINE_LENGTH, len);
            write_reg(REG_START_PARITY, {PAD_BITS'($urandom_range(0, 4095)), par});
        end else begin
            write_reg(REG_START_PARITY, {PAD_BITS'($urandom_range(0, 4095)), par});
            write_reg(REG_LINE_LENGTH, len);
        end
        eff = clamp_len(len);
        n_lines = (eff > 64) ? 0 : $urandom_range(1, 4);
        for (int l = 0; l < n_lines; l++) begin
            for (int i = 0; i < eff; i++)
                send_sample(pick_sample());
            sent += eff;
        end
        // broken line, cut short by the next register write
        if (eff > 64 || (eff > 1 && $urandom_range(0, 4) == 0)) begin
            n_part = $urandom_range(1, (eff - 1 < 30) ? eff - 1 : 30);
            for (int i = 0; i < n_part; i++)
                send_sample(pick_sample());
            sent += n_part;
        end
        drain_line();
    endtask

    // receiver: random stall bursts, one long hold to fill the block
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (fill_hold_req && !fill_hold_done) begin
                m_ready <= 1'b0;
                repeat (FILL_HOLD) @(posedge aclk);
                fill_hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (coeff_expect_q.size() == 0) begin
                $error("unexpected transfer: coeff %0d is_high %0b last %0b",
                       m_coeff, m_is_high, m_last);
                fail_count++;
            end else begin
                head_want = coeff_expect_q.pop_front();
                if (m_coeff !== head_want.coeff) begin
                    $error("coeff: expected %0d, got %0d", head_want.coeff, m_coeff);
                    fail_count++;
                end
                if (m_is_high !== head_want.is_high) begin
                    $error("is_high: expected %0b, got %0b", head_want.is_high, m_is_high);
                    fail_count++;
                end
                if (m_last !== head_want.last) begin
                    $error("last: expected %0b, got %0b", head_want.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        int sent;
        int items;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_LINE_LENGTH;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_sample  <= '0;
        line_len_cfg = 1;
        parity_cfg   = 1'b0;
        win          = '{0, 0, 0};
        last_high    = 0;
        held_low     = 0;
        pos_in_line  = 0;

        directed_rows = '{
            // reset state: one-sample lines at even position
            '{ROW_SAMPLE_CHK, REG_LINE_LENGTH, 13'd0, 16'sd5, 18'sd5, 1'b0, 1'b1},
            '{ROW_SAMPLE_CHK, REG_LINE_LENGTH, 13'd0, 16'sh8000, -18'sd32768, 1'b0, 1'b1},
            '{ROW_SAMPLE_CHK, REG_LINE_LENGTH, 13'd0, 16'sh7FFF, 18'sd32767, 1'b0, 1'b1},
            // odd start: the lone sample doubles
            '{ROW_CFG, REG_START_PARITY, 13'd1, 16'sd0, 18'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE_CHK, REG_LINE_LENGTH, 13'd0, 16'sh7FFF, 18'sd65534, 1'b1, 1'b1},
            '{ROW_SAMPLE_CHK, REG_LINE_LENGTH, 13'd0, 16'sh8000, -18'sd65536, 1'b1, 1'b1},
            // zero length acts as one
            '{ROW_CFG, REG_LINE_LENGTH, 13'd0, 16'sd0, 18'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE_CHK, REG_LINE_LENGTH, 13'd0, -16'sd3, -18'sd6, 1'b1, 1'b1},
            // two-sample lines, even start, extremes
            '{ROW_CFG, REG_START_PARITY, 13'd0, 16'sd0, 18'sd0, 1'b0, 1'b0},
            '{ROW_CFG, REG_LINE_LENGTH, 13'd2, 16'sd0, 18'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE, REG_LINE_LENGTH, 13'd0, 16'sh8000, 18'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE, REG_LINE_LENGTH, 13'd0, 16'sh7FFF, 18'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE, REG_LINE_LENGTH, 13'd0, 16'sd7, 18'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE, REG_LINE_LENGTH, 13'd0, -16'sd4, 18'sd0, 1'b0, 1'b0},
            // three samples, odd start, largest high-pass swing
            '{ROW_CFG, REG_LINE_LENGTH, 13'd3, 16'sd0, 18'sd0, 1'b0, 1'b0},
            '{ROW_CFG, REG_START_PARITY, 13'd1, 16'sd0, 18'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE, REG_LINE_LENGTH, 13'd0, 16'sh7FFF, 18'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE, REG_LINE_LENGTH, 13'd0, 16'sh8000, 18'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE, REG_LINE_LENGTH, 13'd0, 16'sh7FFF, 18'sd0, 1'b0, 1'b0},
            // line cut after two samples by a register write
            '{ROW_CFG, REG_LINE_LENGTH, 13'd5, 16'sd0, 18'sd0, 1'b0, 1'b0},
            '{ROW_CFG, REG_START_PARITY, 13'd0, 16'sd0, 18'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE, REG_LINE_LENGTH, 13'd0, 16'sd1, 18'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE, REG_LINE_LENGTH, 13'd0, -16'sd1, 18'sd0, 1'b0, 1'b0},
            '{ROW_CFG, REG_LINE_LENGTH, 13'd4, 16'sd0, 18'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE, REG_LINE_LENGTH, 13'd0, 16'sd0, 18'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE, REG_LINE_LENGTH, 13'd0, 16'sh8000, 18'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE, REG_LINE_LENGTH, 13'd0, 16'sh7FFF, 18'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE, REG_LINE_LENGTH, 13'd0, -16'sd1, 18'sd0, 1'b0, 1'b0}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows
        foreach (directed_rows[r]) begin
            case (directed_rows[r].kind)
                ROW_CFG: begin
                    drain_line();
                    write_reg(directed_rows[r].idx, directed_rows[r].val);
                end
                ROW_SAMPLE: begin
                    send_sample(directed_rows[r].smp);
                end
                default: begin
                    // typed value replaces the predicted one for this lone sample
                    send_sample(directed_rows[r].smp);
                    void'(coeff_expect_q.pop_back());
                    push_coeff(directed_rows[r].w_coeff, directed_rows[r].w_high,
                               directed_rows[r].w_last);
                end
            endcase
        end
        drain_line();

        // oversize length, broken line with the long receiver hold inside it
        write_reg(REG_LINE_LENGTH, {LEN_BITS{1'b1}});
        write_reg(REG_START_PARITY, {PAD_BITS'($urandom_range(0, 4095)), 1'b0});
        for (int i = 0; i < FILL_SAMPLES; i++) begin
            if (i == 10)
                fill_hold_req = 1'b1;
            send_sample(pick_sample());
        end
        drain_line();

        // exact maximum length, cut short
        write_reg(REG_LINE_LENGTH, LEN_BITS'(MAX_LEN));
        write_reg(REG_START_PARITY, {PAD_BITS'($urandom_range(0, 4095)), 1'b1});
        for (int i = 0; i < 20; i++)
            send_sample(pick_sample());
        drain_line();

        // random phases
        items = 0;
        while (items < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            run_phase(sent);
            items += sent;
        end

        // closing stretch without idling
        calm = 1'b1;
        run_phase(sent);

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
